// File: sv/backward_lz_decompressor_defines.svh
`ifndef BACKWARD_LZ_DECOMPRESSOR_DEFINES_SVH
`define BACKWARD_LZ_DECOMPRESSOR_DEFINES_SVH

// check on every edge, reset included
`define BLZD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// check outside reset
`define BLZD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// File: sv/blzd_pkg.sv
package blzd_pkg;

   localparam int unsigned WINDOW_DEPTH_DEF = 8192;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned COUNT_W          = 32;
   localparam int unsigned LEN_BITS         = 4;
   localparam int unsigned DIST_BITS        = 12;
   localparam int unsigned MATCH_BIAS       = 3;
   localparam int unsigned LEN_W            = LEN_BITS + 1;
   localparam int unsigned DIST_W           = DIST_BITS + 1;
   localparam int unsigned FLAGS_W          = 4;
   localparam logic [FLAGS_W-1:0] FLAGS_PER_CONTROL = 4'd8;

   typedef struct packed {
      logic literal;
      logic high_load;
      logic pair_start;
      logic issue;
      logic emit;
      logic last;
   } blzd_cmd_type;

   typedef struct packed {
      logic             remaining_zero;
      logic             remaining_one;
      logic             out_free;
      logic [LEN_W-1:0] match_len;
   } blzd_status_type;

endpackage

// File: sv/blzd_if.sv
interface blzd_req_if;
   import blzd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface blzd_rsp_if;
   import blzd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;
   logic              finished;
   logic              bad_distance;
   modport source (output valid, output out_byte, output last_of_run, output finished,
                   output bad_distance, input ready);
   modport sink (input valid, input out_byte, input last_of_run, input finished,
                 input bad_distance, output ready);
endinterface

interface blzd_csr_if;
   import blzd_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] output_length;
   modport source (output valid, output output_length, input ready);
   modport sink (input valid, input output_length, output ready);
endinterface

// File: sv/blzd_ram.sv
module blzd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8192,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/blzd_ctrl.sv
module blzd_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [blzd_pkg::BYTE_W-1:0]  req_byte,
   output logic                         req_ready,
   input  logic                         csr_write,
   input  blzd_pkg::blzd_status_type    status,
   output blzd_pkg::blzd_cmd_type       cmd
);
   import blzd_pkg::*;

   localparam logic ST_ACCEPT = 1'b0;
   localparam logic ST_COPY   = 1'b1;

   logic               state_ff, state_in;
   logic [BYTE_W-1:0]  flag_byte_ff, flag_byte_in;
   logic [FLAGS_W-1:0] flags_left_ff, flags_left_in;
   logic               pair_pending_ff, pair_pending_in;
   logic [LEN_W-1:0]   issue_left_ff, issue_left_in;
   logic [LEN_W-1:0]   emit_left_ff, emit_left_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               in_fire;

   always_comb begin
      state_in        = state_ff;
      flag_byte_in    = flag_byte_ff;
      flags_left_in   = flags_left_ff;
      pair_pending_in = pair_pending_ff;
      issue_left_in   = issue_left_ff;
      emit_left_in    = emit_left_ff;
      rd_pend_in      = rd_pend_ff;
      cmd             = '0;
      req_ready       = (state_ff == ST_ACCEPT) && status.out_free;
      in_fire         = req_valid && req_ready;

      unique case (state_ff)
         ST_ACCEPT: begin
            if (in_fire && !status.remaining_zero) begin
               if (flags_left_ff == '0) begin
                  flag_byte_in  = req_byte;
                  flags_left_in = FLAGS_PER_CONTROL;
               end else if (pair_pending_ff) begin
                  cmd.pair_start  = 1'b1;
                  pair_pending_in = 1'b0;
                  issue_left_in   = status.match_len;
                  emit_left_in    = status.match_len;
                  state_in        = ST_COPY;
               end else if (flag_byte_ff[BYTE_W-1]) begin
                  cmd.high_load   = 1'b1;
                  pair_pending_in = 1'b1;
               end else begin
                  cmd.literal   = 1'b1;
                  flag_byte_in  = flag_byte_ff << 1;
                  flags_left_in = flags_left_ff - 1'b1;
                  if (status.remaining_one) begin
                     flags_left_in = '0;
                  end
               end
            end
         end
         ST_COPY: begin
            cmd.emit  = rd_pend_ff && status.out_free;
            cmd.last  = (emit_left_ff == LEN_W'(1));
            cmd.issue = (issue_left_ff != '0) && (!rd_pend_ff || cmd.emit);
            if (cmd.issue) begin
               issue_left_in = issue_left_ff - 1'b1;
               rd_pend_in    = 1'b1;
            end else if (cmd.emit) begin
               rd_pend_in = 1'b0;
            end
            if (cmd.emit) begin
               emit_left_in = emit_left_ff - 1'b1;
               if (cmd.last) begin
                  state_in      = ST_ACCEPT;
                  flag_byte_in  = flag_byte_ff << 1;
                  flags_left_in = flags_left_ff - 1'b1;
                  if (status.remaining_one) begin
                     flags_left_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase

      if (csr_write) begin
         flags_left_in   = '0;
         pair_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_ACCEPT;
         flag_byte_ff    <= '0;
         flags_left_ff   <= '0;
         pair_pending_ff <= 1'b0;
         issue_left_ff   <= '0;
         emit_left_ff    <= '0;
         rd_pend_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         flag_byte_ff    <= flag_byte_in;
         flags_left_ff   <= flags_left_in;
         pair_pending_ff <= pair_pending_in;
         issue_left_ff   <= issue_left_in;
         emit_left_ff    <= emit_left_in;
         rd_pend_ff      <= rd_pend_in;
      end
   end

endmodule

// File: sv/blzd_dp.sv
module blzd_dp #(
   parameter int unsigned WINDOW_DEPTH = blzd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [blzd_pkg::BYTE_W-1:0]   req_byte,
   input  logic                          csr_write,
   input  logic [blzd_pkg::COUNT_W-1:0]  csr_value,
   input  blzd_pkg::blzd_cmd_type        cmd,
   output blzd_pkg::blzd_status_type     status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [blzd_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_last_of_run,
   output logic                          rsp_finished,
   output logic                          rsp_bad_distance
);
   import blzd_pkg::*;

   localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(WINDOW_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);
   localparam int unsigned DIST_HI_W = DIST_BITS - BYTE_W;

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic               wrapped_ff, wrapped_in;
   logic [PTR_W-1:0]   rd_addr_ff, rd_addr_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [COUNT_W-1:0] remaining_ff, remaining_in;
   logic [COUNT_W-1:0] produced_ff, produced_in;
   logic [BYTE_W-1:0]  high_byte_ff, high_byte_in;
   logic               bad_ff, bad_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               last_ff, last_in;
   logic               finished_ff, finished_in;
   logic               out_bad_ff, out_bad_in;

   logic [LEN_W-1:0]   len_raw;
   logic [DIST_W-1:0]  match_dist;
   logic [PTR_W:0]     rd_start_sum;
   logic [PTR_W:0]     rd_start_wrap;
   logic               load;
   logic [BYTE_W-1:0]  load_byte;
   logic [BYTE_W-1:0]  ram_rd_data;

   blzd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (wr_ptr_ff),
      .wr_data (load_byte),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      len_raw = LEN_W'(high_byte_ff[BYTE_W-1 -: LEN_BITS]) + LEN_W'(MATCH_BIAS);
      match_dist = DIST_W'({high_byte_ff[DIST_HI_W-1:0], req_byte}) + DIST_W'(MATCH_BIAS);
      rd_start_sum  = {1'b0, wr_ptr_ff} + DEPTH_EXT - (PTR_W + 1)'(match_dist);
      rd_start_wrap = (rd_start_sum >= DEPTH_EXT) ? (rd_start_sum - DEPTH_EXT) : rd_start_sum;

      status.remaining_zero = (remaining_ff == '0);
      status.remaining_one  = (remaining_ff == COUNT_W'(1));
      status.out_free       = !rsp_valid_ff || rsp_ready;
      status.match_len      = (remaining_ff < COUNT_W'(len_raw)) ?
                              remaining_ff[LEN_W-1:0] : len_raw;

      load      = cmd.literal || cmd.emit;
      load_byte = cmd.literal ? req_byte : (rd_ok_ff ? ram_rd_data : '0);

      wr_ptr_in    = wr_ptr_ff;
      wrapped_in   = wrapped_ff;
      rd_addr_in   = rd_addr_ff;
      rd_ok_in     = rd_ok_ff;
      remaining_in = remaining_ff;
      produced_in  = produced_ff;
      high_byte_in = high_byte_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      finished_in  = finished_ff;
      out_bad_in   = out_bad_ff;

      if (cmd.high_load) begin
         high_byte_in = req_byte;
      end

      if (cmd.pair_start) begin
         bad_in     = (COUNT_W'(match_dist) > produced_ff);
         rd_addr_in = rd_start_wrap[PTR_W-1:0];
      end

      if (cmd.issue) begin
         rd_addr_in = (rd_addr_ff == PTR_LAST) ? '0 : rd_addr_ff + 1'b1;
         rd_ok_in   = wrapped_ff || (rd_addr_ff < wr_ptr_ff);
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = load_byte;
         last_in      = cmd.literal || cmd.last;
         finished_in  = status.remaining_one;
         out_bad_in   = cmd.emit && bad_ff;
         remaining_in = remaining_ff - 1'b1;
         produced_in  = produced_ff + 1'b1;
         if (wr_ptr_ff == PTR_LAST) begin
            wr_ptr_in  = '0;
            wrapped_in = 1'b1;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         remaining_in = csr_value;
         produced_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         wrapped_ff   <= 1'b0;
         rd_ok_ff     <= 1'b0;
         remaining_ff <= '0;
         produced_ff  <= '0;
         high_byte_ff <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         wrapped_ff   <= wrapped_in;
         rd_ok_ff     <= rd_ok_in;
         remaining_ff <= remaining_in;
         produced_ff  <= produced_in;
         high_byte_ff <= high_byte_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
      finished_ff <= finished_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_finished     = finished_ff;
   assign rsp_bad_distance = out_bad_ff;

endmodule

// File: sv/backward_lz_decompressor.sv
// Channel   Direction  Transaction
// req_chan  in         one compressed byte (in_byte), last-to-first
// rsp_chan  out        one decompressed byte with last_of_run, finished, bad_distance
// csr_chan  in         write of output_length; restarts parsing
//
// Control, high match and literal bytes are each handled as they are accepted.
// A match word is accepted, then the history read runs one byte ahead of the
// output, with one output byte per cycle while the output register is free.
// Reset needs no clearing pass: history not yet written reads as zero.
// Stalls: the output register holds; req_chan is held off during a match copy
// and while the output register is full and not being taken.
module backward_lz_decompressor #(
   parameter int unsigned WINDOW_DEPTH = blzd_pkg::WINDOW_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   blzd_req_if.sink    req_chan,
   blzd_rsp_if.source  rsp_chan,
   blzd_csr_if.sink    csr_chan
);
   import blzd_pkg::*;

   blzd_cmd_type    cmd;
   blzd_status_type status;
   logic            csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   blzd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_byte  (req_chan.in_byte),
      .req_ready (req_chan.ready),
      .csr_write (csr_write),
      .status    (status),
      .cmd       (cmd)
   );

   blzd_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_byte         (req_chan.in_byte),
      .csr_write        (csr_write),
      .csr_value        (csr_chan.output_length),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_out_byte     (rsp_chan.out_byte),
      .rsp_last_of_run  (rsp_chan.last_of_run),
      .rsp_finished     (rsp_chan.finished),
      .rsp_bad_distance (rsp_chan.bad_distance)
   );

endmodule

// File: sv/blzd_checker.sv
`include "backward_lz_decompressor_defines.svh"

module blzd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [blzd_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                        rsp_last_of_run,
   input logic                        rsp_bad_distance
);
   import blzd_pkg::*;

   logic rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   `BLZD_ASSERT(a_reset_empties_output, reset |=> !rsp_valid, "output valid after reset")
   `BLZD_ASSERT_RST(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte), "stalled transaction changed")
   `BLZD_ASSERT_RST(a_match_streams, rsp_fire && !rsp_last_of_run |=> rsp_valid, "match byte missing in next cycle")
   `BLZD_ASSERT_RST(a_bad_sticks, rsp_fire && !rsp_last_of_run && rsp_bad_distance |=> rsp_bad_distance, "bad distance dropped inside match")

endmodule

bind backward_lz_decompressor blzd_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_byte     (rsp_chan.out_byte),
   .rsp_last_of_run  (rsp_chan.last_of_run),
   .rsp_bad_distance (rsp_chan.bad_distance)
);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import blzd_pkg::*;

   localparam int unsigned WIN = WINDOW_DEPTH_DEF;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned RANDOM_ITEMS = 320;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last_of_run;
      logic              finished;
      logic              bad_distance;
   } blz_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   blzd_req_if req_bus ();
   blzd_rsp_if rsp_bus ();
   blzd_csr_if csr_bus ();

   backward_lz_decompressor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   logic [BYTE_W-1:0] byte_queue [$];
   blz_out_type       expected_out [$];
   blz_out_type       want_out;
   int unsigned       error_count = 0;

   logic [BYTE_W-1:0]  window_mem [WIN];
   int unsigned        write_ptr;
   logic [COUNT_W-1:0] total_len;
   logic [COUNT_W-1:0] bytes_left;
   logic [BYTE_W-1:0]  flag_bits;
   logic [3:0]         flag_count;
   logic               match_pending;
   logic [BYTE_W-1:0]  match_high;

   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned rsp_cycle = 0;
   int unsigned stall_mode = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t ns: %s got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic append_output(input logic [BYTE_W-1:0] value, input logic far,
                                input logic last);
      blz_out_type item;
      window_mem[write_ptr] = value;
      write_ptr = (write_ptr + 1) % WIN;
      bytes_left = bytes_left - 1;
      item.data = value;
      item.last_of_run = last;
      item.finished = (bytes_left == 0);
      item.bad_distance = far;
      expected_out.push_back(item);
   endtask

   task automatic advance_flag();
      flag_bits = flag_bits << 1;
      flag_count = flag_count - 4'd1;
      if (bytes_left == 0) begin
         flag_count = '0;
         match_pending = 1'b0;
      end
   endtask

   task automatic expand_byte(input logic [BYTE_W-1:0] b);
      logic [15:0] word;
      int unsigned run_len;
      int unsigned match_dist;
      int unsigned produced;
      logic        far;
      if (bytes_left == 0) begin
      end else if (flag_count == 0) begin
         flag_bits = b;
         flag_count = 4'd8;
      end else if (match_pending) begin
         word = {match_high, b};
         run_len = word[15:DIST_BITS] + MATCH_BIAS;
         match_dist = word[DIST_BITS-1:0] + MATCH_BIAS;
         produced = total_len - bytes_left;
         far = match_dist > produced;
         if (run_len > bytes_left) run_len = bytes_left;
         match_pending = 1'b0;
         for (int i = 0; i < run_len; i++) begin
            append_output(window_mem[(write_ptr + WIN - match_dist) % WIN], far,
                          i == run_len - 1);
         end
         advance_flag();
      end else if (flag_bits[BYTE_W-1]) begin
         match_high = b;
         match_pending = 1'b1;
      end else begin
         append_output(b, 1'b0, 1'b1);
         advance_flag();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (window_mem[i]) window_mem[i] = '0;
         write_ptr = 0;
         total_len = '0;
         bytes_left = '0;
         flag_bits = '0;
         flag_count = '0;
         match_pending = 1'b0;
         match_high = '0;
         expected_out.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_out.size() == 0) begin
               report_mismatch("unexpected out_byte", rsp_bus.out_byte, '0);
            end else begin
               want_out = expected_out.pop_front();
               if (rsp_bus.out_byte !== want_out.data)
                  report_mismatch("out_byte", rsp_bus.out_byte, want_out.data);
               if (rsp_bus.last_of_run !== want_out.last_of_run)
                  report_mismatch("last_of_run", rsp_bus.last_of_run, want_out.last_of_run);
               if (rsp_bus.finished !== want_out.finished)
                  report_mismatch("finished", rsp_bus.finished, want_out.finished);
               if (rsp_bus.bad_distance !== want_out.bad_distance)
                  report_mismatch("bad_distance", rsp_bus.bad_distance,
                                  want_out.bad_distance);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            total_len = csr_bus.output_length;
            bytes_left = csr_bus.output_length;
            flag_bits = '0;
            flag_count = '0;
            match_pending = 1'b0;
            match_high = '0;
         end
         if (req_bus.valid && req_bus.ready) expand_byte(req_bus.in_byte);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (gap_left != 0 || byte_queue.size() == 0) begin
            req_bus.valid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            req_bus.valid <= 1'b1;
            req_bus.in_byte <= byte_queue.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: begin
               rsp_bus.ready <= 1'b1;
            end
            1: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_bus.ready <= (rsp_cycle % 4 == 0);
            end
            default: begin
               rsp_bus.ready <= (rsp_cycle % 16 < 9);
            end
         endcase
      end
   end

   task automatic write_length(input logic [COUNT_W-1:0] len);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.output_length <= len;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (byte_queue.size() != 0 || req_bus.valid || expected_out.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned random_items;
      int unsigned phase_len;
      int unsigned made;
      int unsigned budget;
      int unsigned sent;
      int unsigned run;
      int unsigned reach;
      logic [BYTE_W-1:0] ctrl;
      logic [15:0] word;

      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.output_length = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // drop: no length written yet
      byte_queue = {8'h00, 8'hFF, 8'h80};
      wait_idle();
      write_length('0);
      byte_queue = {8'h00, 8'h7F};
      wait_idle();

      // max-field bad match, exact match, overlapping clipped match, trailing drop
      write_length(30);
      byte_queue = {8'h6C, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h50, 8'h00,
                    8'h12, 8'h34};
      wait_idle();
      write_length(1);
      byte_queue = {8'h80, 8'h30, 8'h00};
      wait_idle();
      write_length('1);
      byte_queue = {8'h10, 8'h01, 8'h02, 8'h03, 8'h10, 8'h00};
      wait_idle();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: phase_len = 32'hFFFF_FFFF;
            1: phase_len = $urandom_range(100, 300);
            2: phase_len = $urandom;
            default: phase_len = $urandom_range(1, 60);
         endcase
         write_length(phase_len);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(5, 20)) begin
               byte_queue.push_back(8'($urandom));
               random_items++;
            end
         end else begin
            made = 0;
            sent = 0;
            budget = $urandom_range(20, 80);
            while (made < phase_len && sent < budget) begin
               ctrl = 8'($urandom);
               byte_queue.push_back(ctrl);
               sent++;
               for (int f = BYTE_W - 1; f >= 0 && made < phase_len; f--) begin
                  if (ctrl[f]) begin
                     reach = (made > 4098) ? 4098 : made;
                     if (reach >= MATCH_BIAS && $urandom_range(0, 7) != 0)
                        word[DIST_BITS-1:0] =
                           DIST_BITS'($urandom_range(0, reach - MATCH_BIAS));
                     else
                        word[DIST_BITS-1:0] = DIST_BITS'($urandom);
                     word[15:DIST_BITS] = LEN_BITS'($urandom);
                     byte_queue.push_back(word[15:8]);
                     byte_queue.push_back(word[7:0]);
                     sent += 2;
                     run = word[15:DIST_BITS] + MATCH_BIAS;
                     made += (run > phase_len - made) ? phase_len - made : run;
                  end else begin
                     byte_queue.push_back(8'($urandom));
                     sent++;
                     made++;
                  end
               end
            end
            // broken tail: a lone control byte with no items after it
            if (made < phase_len && $urandom_range(0, 3) == 0)
               byte_queue.push_back(8'($urandom));
            if (made >= phase_len)
               repeat ($urandom_range(0, 3)) byte_queue.push_back(8'($urandom));
            random_items += sent;
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
